// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/hrhp_pkg.sv -----
package hrhp_pkg;

   // Default counter width for content length and body count
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int          NAME_LEN   = 14;
   localparam logic [7:0]  CH_CR      = 8'h0D;
   localparam logic [7:0]  CH_LF      = 8'h0A;
   localparam logic [7:0]  CH_COLON   = 8'h3A;
   localparam logic [7:0]  CH_SPACE   = 8'h20;
   localparam logic [15:0] OK_STATUS  = 16'd200;
   localparam logic [15:0] STATUS_MAX = 16'hFFFF;

   // Result codes
   localparam logic [2:0] RC_OK          = 3'd0;
   localparam logic [2:0] RC_READ_ERROR  = 3'd1;
   localparam logic [2:0] RC_LEN_UNKNOWN = 3'd2;
   localparam logic [2:0] RC_STATUS_ERR  = 3'd3;
   localparam logic [2:0] RC_LEN_MISMTCH = 3'd4;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   // Status number: before space, skipping blanks, digits, done
   typedef enum logic [1:0] {
      ST_WAIT_SPACE = 2'd0,
      ST_SKIP       = 2'd1,
      ST_DIGITS     = 2'd2,
      ST_DONE       = 2'd3
   } status_phase_type;

   // Value number: skipping blanks, digits, done
   typedef enum logic [1:0] {
      VL_SKIP   = 2'd0,
      VL_DIGITS = 2'd1,
      VL_DONE   = 2'd2
   } value_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [15:0] status_code;
      logic [31:0] content_length;
      logic [31:0] body_bytes;
   } rsp_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
   endfunction

   // Characters of "content-length"
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/http_response_header_parser_core.sv -----
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | hrhp_pkg::req_type (data_byte, stream_end)
// rsp     | out       | rsp_valid/rsp_stall  | hrhp_pkg::rsp_type (code, status, length, body)
//
// One byte per cycle while req_stall is low: every byte updates the parser state in the cycle it is accepted.
// A stream_end transaction loads its result at the accepting edge into the output register,
// or into the skid register while the output register holds a stalled result.
// A two-entry output (result register plus skid register) keeps input flowing while a
// result waits; input stalls only when both entries are full.
// Reset is synchronous, active high, and clears all parser and handshake state.
`include "assert_macros.svh"

module http_response_header_parser_core #(
   parameter int COUNT_WIDTH = hrhp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrhp_pkg::rsp_type rsp_data
);

   localparam int NAME_IDX_W = 4;

   // Parser state
   hrhp_pkg::phase_type        phase_ff, phase_in;
   logic [1:0]                 line_pos_ff, line_pos_in;
   logic                       first_cr_ff, first_cr_in;
   logic                       has_colon_ff, has_colon_in;
   logic [NAME_IDX_W-1:0]      name_idx_ff, name_idx_in;
   logic                       name_miss_ff, name_miss_in;
   hrhp_pkg::value_phase_type  val_phase_ff, val_phase_in;
   logic [COUNT_WIDTH-1:0]     val_acc_ff, val_acc_in;
   hrhp_pkg::status_phase_type st_phase_ff, st_phase_in;
   logic [15:0]                st_acc_ff, st_acc_in;
   logic [15:0]                status_ff, status_in;
   logic [COUNT_WIDTH-1:0]     length_ff, length_in;
   logic [COUNT_WIDTH-1:0]     body_cnt_ff, body_cnt_in;
   logic [7:0]                 held_ff, held_in;

   // Output register and skid register
   logic              rsp_valid_ff, rsp_valid_in;
   hrhp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   hrhp_pkg::rsp_type skid_data_ff, skid_data_in;

   logic              req_accept;
   logic              new_result;
   hrhp_pkg::rsp_type result;

   // Arithmetic helpers
   logic [7:0]             cb;
   logic [3:0]             digit;
   logic [COUNT_WIDTH+3:0] val_wide;
   logic [COUNT_WIDTH-1:0] val_push;
   logic [19:0]            st_wide;
   logic [15:0]            st_push;
   logic [COUNT_WIDTH+31:0] length_ext;
   logic [COUNT_WIDTH+31:0] body_ext;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign new_result = req_accept && req_data.stream_end;

   // Decimal push of the held content byte, saturating
   assign cb       = held_ff;
   assign digit    = cb[3:0];
   assign val_wide = ({4'b0, val_acc_ff} << 3) + ({4'b0, val_acc_ff} << 1)
                     + (COUNT_WIDTH + 4)'(digit);
   assign val_push = (val_wide[COUNT_WIDTH+3:COUNT_WIDTH] != 4'b0) ? '1
                     : val_wide[COUNT_WIDTH-1:0];
   assign st_wide  = ({4'b0, st_acc_ff} << 3) + ({4'b0, st_acc_ff} << 1) + 20'(digit);
   assign st_push  = (st_wide[19:16] != 4'b0) ? hrhp_pkg::STATUS_MAX : st_wide[15:0];

   // Build the result from the state before this transaction
   assign length_ext = {32'b0, length_ff};
   assign body_ext   = {32'b0, body_cnt_ff};

   always_comb begin
      result.status_code    = status_ff;
      result.content_length = length_ext[31:0];
      result.body_bytes     = 32'b0;
      if (phase_ff != hrhp_pkg::PH_BODY) begin
         result.result_code = hrhp_pkg::RC_READ_ERROR;
      end else begin
         result.body_bytes = body_ext[31:0];
         if (status_ff != hrhp_pkg::OK_STATUS) begin
            result.result_code = hrhp_pkg::RC_STATUS_ERR;
         end else if (length_ff == '0) begin
            result.result_code = hrhp_pkg::RC_LEN_UNKNOWN;
         end else if (body_cnt_ff != length_ff) begin
            result.result_code = hrhp_pkg::RC_LEN_MISMTCH;
         end else begin
            result.result_code = hrhp_pkg::RC_OK;
         end
      end
   end

   // Next parser state
   always_comb begin
      phase_in     = phase_ff;
      line_pos_in  = line_pos_ff;
      first_cr_in  = first_cr_ff;
      has_colon_in = has_colon_ff;
      name_idx_in  = name_idx_ff;
      name_miss_in = name_miss_ff;
      val_phase_in = val_phase_ff;
      val_acc_in   = val_acc_ff;
      st_phase_in  = st_phase_ff;
      st_acc_in    = st_acc_ff;
      status_in    = status_ff;
      length_in    = length_ff;
      body_cnt_in  = body_cnt_ff;
      held_in      = held_ff;

      if (req_accept) begin
         if (req_data.stream_end) begin
            // Return to the reset state for the next response
            phase_in     = hrhp_pkg::PH_HEADER;
            line_pos_in  = 2'd0;
            first_cr_in  = 1'b0;
            has_colon_in = 1'b0;
            name_idx_in  = '0;
            name_miss_in = 1'b0;
            val_phase_in = hrhp_pkg::VL_SKIP;
            val_acc_in   = '0;
            st_phase_in  = hrhp_pkg::ST_WAIT_SPACE;
            st_acc_in    = 16'd0;
            status_in    = 16'd0;
            length_in    = '0;
            body_cnt_in  = '0;
            held_in      = 8'd0;
         end else begin
            case (phase_ff)
               hrhp_pkg::PH_BODY: begin
                  if (body_cnt_ff != '1) begin
                     body_cnt_in = body_cnt_ff + COUNT_WIDTH'(1);
                  end
               end
               hrhp_pkg::PH_HEADER: begin
                  if (req_data.data_byte == hrhp_pkg::CH_LF) begin
                     // Close the line
                     if (line_pos_ff == 2'd0) begin
                        phase_in = hrhp_pkg::PH_ERROR;
                     end else if (line_pos_ff == 2'd1 && first_cr_ff) begin
                        phase_in = hrhp_pkg::PH_BODY;
                     end else if (!has_colon_ff) begin
                        status_in = (st_phase_ff == hrhp_pkg::ST_DIGITS ||
                                     st_phase_ff == hrhp_pkg::ST_DONE) ? st_acc_ff : 16'd0;
                     end else if (!name_miss_ff &&
                                  name_idx_ff == NAME_IDX_W'(hrhp_pkg::NAME_LEN)) begin
                        length_in = val_acc_ff;
                     end
                     line_pos_in  = 2'd0;
                     first_cr_in  = 1'b0;
                     has_colon_in = 1'b0;
                     name_idx_in  = '0;
                     name_miss_in = 1'b0;
                     val_phase_in = hrhp_pkg::VL_SKIP;
                     val_acc_in   = '0;
                     st_phase_in  = hrhp_pkg::ST_WAIT_SPACE;
                     st_acc_in    = 16'd0;
                     held_in      = 8'd0;
                  end else begin
                     if (line_pos_ff != 2'd0) begin
                        // Status number from the held byte
                        case (st_phase_ff)
                           hrhp_pkg::ST_WAIT_SPACE: begin
                              if (cb == hrhp_pkg::CH_SPACE) begin
                                 st_phase_in = hrhp_pkg::ST_SKIP;
                              end
                           end
                           hrhp_pkg::ST_SKIP: begin
                              if (hrhp_pkg::is_digit(cb)) begin
                                 st_acc_in   = st_push;
                                 st_phase_in = hrhp_pkg::ST_DIGITS;
                              end else if (!hrhp_pkg::is_blank(cb)) begin
                                 st_phase_in = hrhp_pkg::ST_DONE;
                              end
                           end
                           hrhp_pkg::ST_DIGITS: begin
                              if (hrhp_pkg::is_digit(cb)) begin
                                 st_acc_in = st_push;
                              end else begin
                                 st_phase_in = hrhp_pkg::ST_DONE;
                              end
                           end
                           default: begin
                           end
                        endcase
                        // Header name match, then value number
                        if (!has_colon_ff) begin
                           if (cb == hrhp_pkg::CH_COLON) begin
                              has_colon_in = 1'b1;
                           end else if (name_idx_ff < NAME_IDX_W'(hrhp_pkg::NAME_LEN) &&
                                        hrhp_pkg::to_lower(cb) ==
                                        hrhp_pkg::name_char(name_idx_ff)) begin
                              name_idx_in = name_idx_ff + NAME_IDX_W'(1);
                           end else begin
                              name_miss_in = 1'b1;
                           end
                        end else begin
                           case (val_phase_ff)
                              hrhp_pkg::VL_SKIP: begin
                                 if (hrhp_pkg::is_digit(cb)) begin
                                    val_acc_in   = val_push;
                                    val_phase_in = hrhp_pkg::VL_DIGITS;
                                 end else if (!hrhp_pkg::is_blank(cb)) begin
                                    val_phase_in = hrhp_pkg::VL_DONE;
                                 end
                              end
                              hrhp_pkg::VL_DIGITS: begin
                                 if (hrhp_pkg::is_digit(cb)) begin
                                    val_acc_in = val_push;
                                 end else begin
                                    val_phase_in = hrhp_pkg::VL_DONE;
                                 end
                              end
                              default: begin
                              end
                           endcase
                        end
                     end else begin
                        first_cr_in = (req_data.data_byte == hrhp_pkg::CH_CR);
                     end
                     held_in = req_data.data_byte;
                     if (line_pos_ff != 2'd2) begin
                        line_pos_in = line_pos_ff + 2'd1;
                     end
                  end
               end
               default: begin
                  // Error phase: drop bytes until stream end
               end
            endcase
         end
      end
   end

   // Output register with skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (new_result) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (new_result) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hrhp_pkg::PH_HEADER;
         line_pos_ff   <= 2'd0;
         first_cr_ff   <= 1'b0;
         has_colon_ff  <= 1'b0;
         name_idx_ff   <= '0;
         name_miss_ff  <= 1'b0;
         val_phase_ff  <= hrhp_pkg::VL_SKIP;
         val_acc_ff    <= '0;
         st_phase_ff   <= hrhp_pkg::ST_WAIT_SPACE;
         st_acc_ff     <= 16'd0;
         status_ff     <= 16'd0;
         length_ff     <= '0;
         body_cnt_ff   <= '0;
         held_ff       <= 8'd0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         line_pos_ff   <= line_pos_in;
         first_cr_ff   <= first_cr_in;
         has_colon_ff  <= has_colon_in;
         name_idx_ff   <= name_idx_in;
         name_miss_ff  <= name_miss_in;
         val_phase_ff  <= val_phase_in;
         val_acc_ff    <= val_acc_in;
         st_phase_ff   <= st_phase_in;
         st_acc_ff     <= st_acc_in;
         status_ff     <= status_in;
         length_ff     <= length_in;
         body_cnt_ff   <= body_cnt_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payloads
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_SAME_CYCLE(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT_CYCLE(a_end_clears, clock, reset, new_result,
      phase_ff == hrhp_pkg::PH_HEADER && body_cnt_ff == '0 && length_ff == '0)
   `ASSERT_SAME_CYCLE(a_body_in_body, clock, reset, body_cnt_ff != '0, phase_ff == hrhp_pkg::PH_BODY)
   `ASSERT_NEXT_CYCLE(a_stalled_to_skid, clock, reset,
      rsp_valid_ff && rsp_stall && new_result, skid_valid_ff)

endmodule

// ----- verif/tb_http_response_header_parser_core.sv -----
module tb_http_response_header_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   import hrhp_pkg::*;

   localparam int          CW         = COUNT_WIDTH_DEFAULT;
   localparam logic [63:0] LEN_CAP    = {64{1'b1}} >> (64 - CW);
   localparam string       LEN_FIELD  = "content-length";
   localparam int          ITEM_GOAL  = 1100;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       typed;
      rsp_type    want;
   } plan_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   http_response_header_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Parser state mirrored from the byte stream
   phase_type        parse_phase;
   logic [1:0]       line_fill;
   logic             lead_cr;
   logic             colon_seen;
   int               name_pos;
   logic             name_bad;
   value_phase_type  len_state;
   logic [63:0]      len_acc;
   status_phase_type code_state;
   logic [15:0]      code_acc;
   logic [15:0]      status_seen;
   logic [63:0]      len_seen;
   logic [63:0]      body_count;
   logic [7:0]       held_char;

   rsp_type expected_outcomes[$];
   req_type response_bytes[$];
   int      fault_count    = 0;
   int      results_seen   = 0;
   int      items_sent     = 0;
   int      frames_sent    = 0;
   int      code_tally[8];
   logic    calm           = 1'b0;

   function automatic logic blank_char(logic [7:0] b);
      return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic decimal_char(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic [63:0] len_digit(logic [63:0] acc, logic [7:0] b);
      logic [63:0] d;
      d = 64'(b - 8'h30);
      if (acc > (LEN_CAP - d) / 10) return LEN_CAP;
      return acc * 10 + d;
   endfunction

   function automatic logic [15:0] code_digit(logic [15:0] acc, logic [7:0] b);
      logic [31:0] wide;
      wide = 32'(acc) * 10 + 32'(b - 8'h30);
      if (wide > 32'(STATUS_MAX)) return STATUS_MAX;
      return wide[15:0];
   endfunction

   function automatic void clear_line_state();
      line_fill  = '0;
      lead_cr    = 1'b0;
      colon_seen = 1'b0;
      name_pos   = 0;
      name_bad   = 1'b0;
      len_state  = VL_SKIP;
      len_acc    = '0;
      code_state = ST_WAIT_SPACE;
      code_acc   = '0;
      held_char  = '0;
   endfunction

   function automatic void clear_parser();
      parse_phase = PH_HEADER;
      clear_line_state();
      status_seen = '0;
      len_seen    = '0;
      body_count  = '0;
   endfunction

   // Feed one byte that is known to be line content
   function automatic void absorb_content(logic [7:0] b);
      logic [7:0] lc;
      case (code_state)
         ST_WAIT_SPACE: if (b == CH_SPACE) code_state = ST_SKIP;
         ST_SKIP: begin
            if (decimal_char(b)) begin
               code_acc   = code_digit(code_acc, b);
               code_state = ST_DIGITS;
            end else if (!blank_char(b)) begin
               code_state = ST_DONE;
            end
         end
         ST_DIGITS: begin
            if (decimal_char(b)) code_acc = code_digit(code_acc, b);
            else code_state = ST_DONE;
         end
         default: ;
      endcase

      // Match the header name up to the first colon
      if (!colon_seen) begin
         if (b == CH_COLON) begin
            colon_seen = 1'b1;
         end else begin
            lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
            if (name_pos < NAME_LEN && lc == LEN_FIELD[name_pos]) name_pos++;
            else name_bad = 1'b1;
         end
         return;
      end

      case (len_state)
         VL_SKIP: begin
            if (decimal_char(b)) begin
               len_acc   = len_digit(len_acc, b);
               len_state = VL_DIGITS;
            end else if (!blank_char(b)) begin
               len_state = VL_DONE;
            end
         end
         VL_DIGITS: begin
            if (decimal_char(b)) len_acc = len_digit(len_acc, b);
            else len_state = VL_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic void close_line();
      if (line_fill == 0) parse_phase = PH_ERROR;
      else if (line_fill == 1 && lead_cr) parse_phase = PH_BODY;
      else if (!colon_seen) status_seen = (code_state >= ST_DIGITS) ? code_acc : 16'd0;
      else if (!name_bad && name_pos == NAME_LEN) len_seen = len_acc;
      clear_line_state();
   endfunction

   // Advance the parser by one transaction; return 1 when it yields a result
   function automatic logic parse_byte(req_type item, output rsp_type res);
      res = '0;
      if (item.stream_end) begin
         res.status_code    = status_seen;
         res.content_length = len_seen[31:0];
         if (parse_phase != PH_BODY) begin
            res.result_code = RC_READ_ERROR;
         end else begin
            res.body_bytes = body_count[31:0];
            if (status_seen != OK_STATUS) res.result_code = RC_STATUS_ERR;
            else if (len_seen == 0) res.result_code = RC_LEN_UNKNOWN;
            else if (body_count != len_seen) res.result_code = RC_LEN_MISMTCH;
            else res.result_code = RC_OK;
         end
         clear_parser();
         return 1'b1;
      end
      case (parse_phase)
         PH_BODY: if (body_count < LEN_CAP) body_count++;
         PH_HEADER: begin
            if (item.data_byte == CH_LF) begin
               close_line();
            end else begin
               if (line_fill != 0) absorb_content(held_char);
               else lead_cr = (item.data_byte == CH_CR);
               held_char = item.data_byte;
               if (line_fill < 2) line_fill++;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void put(logic [7:0] b);
      response_bytes.push_back('{data_byte: b, stream_end: 1'b0});
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic void put_number(longint unsigned v);
      put_text($sformatf("%0d", v));
   endfunction

   // Mostly CR LF; sometimes another byte before LF
   function automatic void put_eol();
      if ($urandom_range(0, 19) == 0) put(8'($urandom_range(8'h20, 8'h7E)));
      else put(CH_CR);
      put(CH_LF);
   endfunction

   // Drive one transaction, hold it until accepted, then predict
   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      items_sent++;
      if (parse_byte(item, predicted)) begin
         expected_outcomes.push_back(typed ? want : predicted);
         frames_sent++;
      end
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_outcomes.size() == 0) begin
         $display("%0t: unexpected result, got code %0d status %0d length %0d body %0d",
                  $time, got.result_code, got.status_code, got.content_length,
                  got.body_bytes);
         fault_count++;
         return;
      end
      want = expected_outcomes.pop_front();
      results_seen++;
      code_tally[want.result_code]++;
      if (got.result_code !== want.result_code) begin
         $display("%0t: result_code expected %0d, got %0d",
                  $time, want.result_code, got.result_code);
         fault_count++;
      end
      if (got.status_code !== want.status_code) begin
         $display("%0t: status_code expected %0d, got %0d",
                  $time, want.status_code, got.status_code);
         fault_count++;
      end
      if (got.content_length !== want.content_length) begin
         $display("%0t: content_length expected %0d, got %0d",
                  $time, want.content_length, got.content_length);
         fault_count++;
      end
      if (got.body_bytes !== want.body_bytes) begin
         $display("%0t: body_bytes expected %0d, got %0d",
                  $time, want.body_bytes, got.body_bytes);
         fault_count++;
      end
   endtask

   // Result side: check at the falling edge, vary stall at the rising edge
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_result(rsp_data);
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(0, 2) == 0) hold_left = pick_gap();
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Timeout waiting for the parser");
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      plan_row_type    plan[21];
      int unsigned     body_len;
      int unsigned     n_hdr;
      int unsigned     len_slot;
      int unsigned     kind;
      int              idle;
      logic [7:0]      c;

      plan = '{
         // stream ends right after reset
         '{8'h00, 1'b1, 1'b1, '{RC_READ_ERROR, 16'd0, 32'd0, 32'd0}},
         // empty line, then an ignored byte
         '{CH_LF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'h00, 1'b1, 1'b1, '{RC_READ_ERROR, 16'd0, 32'd0, 32'd0}},
         // status 200, byte before LF dropped, bare CR line, one body byte
         '{"H",   1'b0, 1'b0, '0},
         '{" ",   1'b0, 1'b0, '0},
         '{"2",   1'b0, 1'b0, '0},
         '{"0",   1'b0, 1'b0, '0},
         '{"0",   1'b0, 1'b0, '0},
         '{"x",   1'b0, 1'b0, '0},
         '{CH_LF, 1'b0, 1'b0, '0},
         '{CH_CR, 1'b0, 1'b0, '0},
         '{CH_LF, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h5A, 1'b1, 1'b1, '{RC_LEN_UNKNOWN, 16'd200, 32'd0, 32'd1}},
         // status line without a space gives status 0
         '{"Q",   1'b0, 1'b0, '0},
         '{"!",   1'b0, 1'b0, '0},
         '{CH_LF, 1'b0, 1'b0, '0},
         '{CH_CR, 1'b0, 1'b0, '0},
         '{CH_LF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b1, 1'b1, '{RC_STATUS_ERR, 16'd0, 32'd0, 32'd0}}
      };

      foreach (code_tally[i]) code_tally[i] = 0;
      clear_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (plan[i])
         send_item('{data_byte: plan[i].data, stream_end: plan[i].fin},
                   plan[i].typed, plan[i].want);
      drain();

      // Random responses: mostly well formed, some noise and broken ones
      while (items_sent < ITEM_GOAL) begin
         response_bytes.delete();
         calm = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            if ($urandom_range(0, 9) != 0) begin
               if ($urandom_range(0, 1)) put_text("HTTP/1.1");
               else put_text("H");
               put(CH_SPACE);
               repeat ($urandom_range(0, 1)) put($urandom_range(0, 1) ? CH_SPACE : 8'h09);
               case ($urandom_range(0, 9))
                  0:       put_number($urandom_range(0, 999));
                  1:       put_text("99999999");
                  2:       put_text("+200");
                  default: put_text("200");
               endcase
               if ($urandom_range(0, 1)) put_text(" OK");
               put_eol();
            end
            body_len = $urandom_range(0, 12);
            n_hdr    = $urandom_range(0, 2);
            len_slot = $urandom_range(0, n_hdr + ($urandom_range(0, 4) == 0));
            for (int k = 0; k <= n_hdr; k++) begin
               if (k == len_slot) begin
                  case ($urandom_range(0, 9))
                     0: put_text("content-len");
                     1: put_text("content-lengthx");
                     default: begin
                        for (int i = 0; i < LEN_FIELD.len(); i++) begin
                           c = LEN_FIELD[i];
                           if (c >= 8'h61 && $urandom_range(0, 1)) c = c - 8'h20;
                           put(c);
                        end
                     end
                  endcase
                  put(CH_COLON);
                  repeat ($urandom_range(0, 2)) put(CH_SPACE);
                  case ($urandom_range(0, 11))
                     0:       put_text("0");
                     1:       put_text("123456789012");
                     2:       begin put("-"); put_number(body_len); end
                     3:       put_number(body_len + 1);
                     default: put_number(body_len);
                  endcase
                  if ($urandom_range(0, 3) == 0) put_text(" ;x");
               end else begin
                  repeat ($urandom_range(1, 6))
                     put(($urandom_range(0, 7) == 0) ? 8'h2D : 8'($urandom_range(8'h41, 8'h7A)));
                  put(CH_COLON);
                  repeat ($urandom_range(0, 5)) put(8'($urandom_range(8'h20, 8'h7E)));
               end
               put_eol();
            end
            put_eol();
            repeat (body_len) put(8'($urandom_range(0, 255)));
         end else if (kind < 17) begin
            repeat ($urandom_range(0, 30))
               put(($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
         end else if (kind < 19) begin
            // stream ends inside the header
            put_text("H 200");
            put_eol();
            put_text("content-length: 4");
         end else begin
            // empty line ends the header with an error
            put_text("H 200");
            put_eol();
            put(CH_LF);
            repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)));
         end
         response_bytes.push_back('{data_byte: 8'($urandom_range(0, 255)), stream_end: 1'b1});

         foreach (response_bytes[i]) send_item(response_bytes[i], 1'b0, '0);
         if (frames_sent % 16 == 0) drain();
      end

      // Settle: wait for outstanding results before the summary
      req_valid <= 1'b0;
      calm = 1'b0;
      for (idle = 0; expected_outcomes.size() != 0 && idle < 5000; idle++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_outcomes.size());
         fault_count++;
      end

      $display("Sent %0d byte transactions forming %0d responses, checked %0d results.",
               items_sent, frames_sent, results_seen);
      $display("Outcomes: ok %0d, read error %0d, length unknown %0d, status %0d, mismatch %0d",
               code_tally[RC_OK], code_tally[RC_READ_ERROR], code_tally[RC_LEN_UNKNOWN],
               code_tally[RC_STATUS_ERR], code_tally[RC_LEN_MISMTCH]);
      if (fault_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
